/* sv/dhpt_pkg.sv */
// Shared constants for the link transform: CORDIC angle table, gain and row codes.
package dhpt_pkg;

  // Rotation CORDIC on a 32-bit binary angle, Q30 internal values
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_WIDTH = 34;

  localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-k) as a 32-bit binary angle
  localparam logic signed [CORDIC_WIDTH-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
    34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
    34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
  };

  // Matrix rows
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_ONE   = 2'd1;
  localparam logic [1:0] ROW_TWO   = 2'd2;
  localparam logic [1:0] ROW_LAST  = 2'd3;

endpackage

/* sv/dh_parameters_to_transform.sv */
// Modified Denavit-Hartenberg link transform: one link beat in, four matrix rows out.
//
// Each input beat carries a, alpha, d and phi; the block returns the 4x4 link transform
// as four output beats, rows 0 to 3, with tlast on row 3 and the row number in tuser.
// A beat is taken every cycle while s_tready is high into a CORDIC pipeline (two
// sine/cosine units running side by side, CORDIC_STEPS + 1 stages) followed by one
// product stage and the row hold register. The row serializer at the output emits one
// row per cycle while m_tready is high; a new link can enter the hold register as the last
// row of the previous one is taken. Products are rounded half away from zero and
// saturated to the signed VALUE_BITS range.
module dh_parameters_to_transform import dhpt_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,

  // lowest bit up: link_offset, link_twist, link_distance, joint_angle, zero fill
  input  logic [((2*VALUE_BITS+2*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                                            s_tvalid,
  output logic                                            s_tready,

  // lowest bit up: col_zero, col_one, col_two, col_three, zero fill
  output logic [((4*VALUE_BITS+7)/8)*8-1:0] m_tdata,
  // row_index
  output logic [1:0]                        m_tuser,
  // last_row
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready
);

  localparam int FRAC_BITS = VALUE_BITS / 2;
  localparam int LAT       = CORDIC_STEPS + 1;
  localparam int OUT_W     = ((4*VALUE_BITS+7)/8)*8;

  localparam logic signed [VALUE_BITS-1:0] MAXV = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] MINV = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] ONEV = VALUE_BITS'(longint'(1) << FRAC_BITS);
  localparam logic [VALUE_BITS+FRAC_BITS:0] HALF =
    (VALUE_BITS+FRAC_BITS+1)'(longint'(1) << (FRAC_BITS-1));

  // Magnitude product, rounded half up on the magnitude, sign applied, saturated
  function automatic logic signed [VALUE_BITS-1:0] mul_sat(
    input logic signed [VALUE_BITS-1:0]  v,
    input logic signed [FRAC_BITS+1:0]   s
  );
    logic                           neg;
    logic [VALUE_BITS-1:0]          mv;
    logic [FRAC_BITS:0]             ms;
    logic [VALUE_BITS+FRAC_BITS:0]  p;
    logic [VALUE_BITS:0]            r;
    logic signed [VALUE_BITS-1:0]   res;
    neg = v[VALUE_BITS-1] ^ s[FRAC_BITS+1];
    mv  = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    ms  = s[FRAC_BITS+1] ? (~s[FRAC_BITS:0] + 1'b1) : s[FRAC_BITS:0];
    p   = (VALUE_BITS+FRAC_BITS+1)'(mv) * (VALUE_BITS+FRAC_BITS+1)'(ms) + HALF;
    r   = p[VALUE_BITS+FRAC_BITS:FRAC_BITS];
    if (neg) res = VALUE_BITS'(~r + 1'b1);
    else if (r[VALUE_BITS-1] | r[VALUE_BITS]) res = MAXV;
    else res = r[VALUE_BITS-1:0];
    return res;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] neg_sat(
    input logic signed [VALUE_BITS-1:0] v
  );
    return (v == MINV) ? MAXV : -v;
  endfunction

  // Input field unpacking
  logic signed [VALUE_BITS-1:0] in_offset, in_distance;
  logic [ANGLE_BITS-1:0]        in_twist, in_angle;

  assign in_offset   = s_tdata[VALUE_BITS-1:0];
  assign in_twist    = s_tdata[VALUE_BITS+ANGLE_BITS-1:VALUE_BITS];
  assign in_distance = s_tdata[2*VALUE_BITS+ANGLE_BITS-1:VALUE_BITS+ANGLE_BITS];
  assign in_angle    = s_tdata[2*VALUE_BITS+2*ANGLE_BITS-1:2*VALUE_BITS+ANGLE_BITS];

  // Flow control: the front pipeline moves as a whole
  logic       adv;
  logic       load_hold;
  logic       prod_valid;
  logic [2:0] rows_pending;

  assign load_hold = prod_valid &&
                     (rows_pending == 3'd0 || (rows_pending == 3'd1 && m_tready));
  assign adv       = !prod_valid || load_hold;
  assign s_tready  = adv;

  // Valid bits and length payload alongside the CORDIC stages
  logic [LAT-1:0]               vld;
  logic signed [VALUE_BITS-1:0] a_dly [LAT];
  logic signed [VALUE_BITS-1:0] d_dly [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dly[0] <= in_offset;
      d_dly[0] <= in_distance;
      for (int k = 1; k < LAT; k++) begin
        a_dly[k] <= a_dly[k-1];
        d_dly[k] <= d_dly[k-1];
      end
    end
  end

  // Sine and cosine of both angles
  logic signed [FRAC_BITS+1:0] sa, ca, sp, cp;

  dhpt_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_twist (
    .clk     (clk),
    .en      (adv),
    .angle   (in_twist),
    .sin_val (sa),
    .cos_val (ca)
  );

  dhpt_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_joint (
    .clk     (clk),
    .en      (adv),
    .angle   (in_angle),
    .sin_val (sp),
    .cos_val (cp)
  );

  // Product stage
  logic signed [FRAC_BITS+1:0]  p_sa, p_ca, p_sp, p_cp;
  logic signed [VALUE_BITS-1:0] p_a, p_e4, p_e5, p_e7, p_e8, p_e9, p_e11;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv) begin
      prod_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sa  <= sa;
      p_ca  <= ca;
      p_sp  <= sp;
      p_cp  <= cp;
      p_a   <= a_dly[LAT-1];
      p_e4  <= mul_sat(VALUE_BITS'(sp), ca);
      p_e5  <= mul_sat(VALUE_BITS'(cp), ca);
      p_e7  <= neg_sat(mul_sat(d_dly[LAT-1], sa));
      p_e8  <= mul_sat(VALUE_BITS'(sp), sa);
      p_e9  <= mul_sat(VALUE_BITS'(cp), sa);
      p_e11 <= mul_sat(d_dly[LAT-1], ca);
    end
  end

  // Row hold: three computed rows, sent one per beat
  logic signed [VALUE_BITS-1:0] held_entries [12];

  always_ff @(posedge clk) begin
    if (load_hold) begin
      held_entries[0]  <= VALUE_BITS'(p_cp);
      held_entries[1]  <= VALUE_BITS'(-p_sp);
      held_entries[2]  <= '0;
      held_entries[3]  <= p_a;
      held_entries[4]  <= p_e4;
      held_entries[5]  <= p_e5;
      held_entries[6]  <= VALUE_BITS'(-p_sa);
      held_entries[7]  <= p_e7;
      held_entries[8]  <= p_e8;
      held_entries[9]  <= p_e9;
      held_entries[10] <= VALUE_BITS'(p_ca);
      held_entries[11] <= p_e11;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_pending <= 3'd0;
    end else if (load_hold) begin
      rows_pending <= 3'd4;
    end else if (m_tvalid && m_tready) begin
      rows_pending <= rows_pending - 3'd1;
    end
  end

  // Output row select
  logic [1:0]                   row;
  logic signed [VALUE_BITS-1:0] c0, c1, c2, c3;

  assign row = 2'(3'd4 - rows_pending);

  always_comb begin
    case (row)
      ROW_FIRST: begin
        c0 = held_entries[0];
        c1 = held_entries[1];
        c2 = held_entries[2];
        c3 = held_entries[3];
      end
      ROW_ONE: begin
        c0 = held_entries[4];
        c1 = held_entries[5];
        c2 = held_entries[6];
        c3 = held_entries[7];
      end
      ROW_TWO: begin
        c0 = held_entries[8];
        c1 = held_entries[9];
        c2 = held_entries[10];
        c3 = held_entries[11];
      end
      default: begin
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = ONEV;
      end
    endcase
  end

  assign m_tvalid = (rows_pending != 3'd0);
  assign m_tuser  = row;
  assign m_tlast  = (row == ROW_LAST);
  assign m_tdata  = OUT_W'({c3, c2, c1, c0});

  // Checks
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    rows_pending <= 3'd4)
    else $error("row counter out of range");

  a_load_four: assert property (@(posedge clk) disable iff (rst)
    load_hold |=> (rows_pending == 3'd4 && m_tuser == ROW_FIRST))
    else $error("hold load did not start a four-row burst");

  a_prod_kept: assert property (@(posedge clk) disable iff (rst)
    (prod_valid && !adv) |=> (prod_valid && $stable(p_e11) && $stable(p_a)))
    else $error("stalled product stage lost its entry");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !prod_valid |-> s_tready)
    else $error("input stalled with an empty product stage");

endmodule

/* sv/dhpt_cordic.sv */
// Pipelined rotation CORDIC: sine and cosine of a binary angle, rounded and clamped to +-1.0.
module dhpt_cordic import dhpt_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic signed [FRAC_BITS+1:0] sin_val,
  output logic signed [FRAC_BITS+1:0] cos_val
);

  localparam int CW  = CORDIC_WIDTH;
  localparam int RSH = 30 - FRAC_BITS;
  localparam logic signed [CW-1:0] RND = CW'(longint'(1) << (29 - FRAC_BITS));
  localparam logic signed [CW-1:0] ONE = CW'(longint'(1) << FRAC_BITS);

  function automatic logic signed [FRAC_BITS+1:0] round_clamp(
    input logic signed [CW-1:0] v
  );
    logic signed [CW-1:0] r;
    r = (v + RND) >>> RSH;
    if (r > ONE) r = ONE;
    else if (r < -ONE) r = -ONE;
    return r[FRAC_BITS+1:0];
  endfunction

  // Pre-rotation: second and third quadrant turned by pi
  logic [31:0]        turn;
  logic               flip0;
  logic signed [31:0] zu;
  logic signed [CW-1:0] z0;

  assign turn  = {angle, {(32-ANGLE_BITS){1'b0}}};
  assign flip0 = turn[31] ^ turn[30];
  assign zu    = {turn[31] ^ flip0, turn[30:0]};
  assign z0    = CW'(zu);

  logic signed [CW-1:0] xq [CORDIC_STEPS];
  logic signed [CW-1:0] yq [CORDIC_STEPS];
  logic signed [CW-1:0] zq [CORDIC_STEPS];
  logic                 flq [CORDIC_STEPS];

  // One micro-rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi, xn, yn, zn;
    logic                 fi;

    if (k == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z0;
      assign fi = flip0;
    end else begin : g_next
      assign xi = xq[k-1];
      assign yi = yq[k-1];
      assign zi = zq[k-1];
      assign fi = flq[k-1];
    end

    always_comb begin
      if (!zi[CW-1]) begin
        xn = xi - (yi >>> k);
        yn = yi + (xi >>> k);
        zn = zi - ATAN_TURN[k];
      end else begin
        xn = xi + (yi >>> k);
        yn = yi - (xi >>> k);
        zn = zi + ATAN_TURN[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xq[k]  <= xn;
        yq[k]  <= yn;
        zq[k]  <= zn;
        flq[k] <= fi;
      end
    end
  end

  // Undo the pre-rotation, round to the output fraction and clamp
  logic signed [CW-1:0] xf, yf;

  assign xf = flq[CORDIC_STEPS-1] ? -xq[CORDIC_STEPS-1] : xq[CORDIC_STEPS-1];
  assign yf = flq[CORDIC_STEPS-1] ? -yq[CORDIC_STEPS-1] : yq[CORDIC_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= round_clamp(xf);
      sin_val <= round_clamp(yf);
    end
  end

endmodule

/* test/tb.sv */
// Self-checking bench for the link transform block: directed table, then random links.
`timescale 1ns / 1ps

module tb import dhpt_pkg::*; ();

  localparam int TOTAL_LINKS = 310;
  localparam int PLAN_LINKS  = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;

  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_ONE = 32'h0001_0000;
  localparam logic [31:0] VAL_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] VAL_NEG_MAX = 32'h8000_0001;

  // binary angles: half range is pi
  localparam logic [15:0] ANG_ZERO    = 16'h0000;
  localparam logic [15:0] ANG_QUARTER = 16'h4000;
  localparam logic [15:0] ANG_HALF    = 16'h8000;
  localparam logic [15:0] ANG_MQUART  = 16'hC000;

  localparam longint CORDIC_START = 64'sd652032874;
  localparam longint ARC_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1
  };

  // one link description; pinned rows carry the translation column typed in
  typedef struct {
    logic [31:0] offset;
    logic [15:0] twist;
    logic [31:0] distance;
    logic [15:0] joint;
    bit          pinned;
    logic [31:0] span_x;
    logic [31:0] span_y;
    logic [31:0] span_z;
  } link_case_t;

  typedef struct {
    logic [1:0]  index;
    logic [31:0] col [4];
    logic        last;
  } transform_row_t;

  logic        clk;
  logic        rst;
  logic [95:0] s_tdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [127:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready;

  transform_row_t rows_due [$];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  bit             calm = 1'b0;

  dh_parameters_to_transform DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // clamp to the signed 32-bit range
  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // sine and cosine in Q16, rotation CORDIC on the angle widened to 32 bits
  function automatic void sin_cos_q16(input logic [15:0] ang, output longint sn,
                                      output longint cs);
    logic [31:0] u;
    logic        flip;
    longint      x, y, z, dx, dy;
    u = {ang, 16'h0000};
    flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
    // second and third quadrant: turn by pi, negate afterwards
    if (flip) u = u + 32'h8000_0000;
    z = longint'($signed(u));
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARC_STEP[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARC_STEP[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    // Q30 to Q16, round half up, clamp to +-1.0
    x = (x + (64'sd1 <<< 13)) >>> 14;
    y = (y + (64'sd1 <<< 13)) >>> 14;
    cs = (x > 65536) ? 65536 : ((x < -65536) ? -65536 : x);
    sn = (y > 65536) ? 65536 : ((y < -65536) ? -65536 : y);
  endfunction

  // Q16 product, magnitude rounded half away from zero, then saturated
  function automatic longint scale_q16(input longint v, input longint s);
    bit     neg;
    longint mv, ms, r;
    neg = (v < 0) != (s < 0);
    mv = (v < 0) ? -v : v;
    ms = (s < 0) ? -s : s;
    r = (mv * ms + 64'sd32768) >>> 16;
    return sat32(neg ? -r : r);
  endfunction

  // work out the four rows of one link transform and queue them
  function automatic void build_link_transform(input link_case_t lc);
    longint sa, ca, sp, cp, a, d;
    longint ent [12];
    transform_row_t row;
    sin_cos_q16(lc.twist, sa, ca);
    sin_cos_q16(lc.joint, sp, cp);
    a = longint'($signed(lc.offset));
    d = longint'($signed(lc.distance));
    ent[0] = cp;                 ent[1] = sat32(-sp);
    ent[2] = 0;                  ent[3] = a;
    ent[4] = scale_q16(sp, ca);  ent[5] = scale_q16(cp, ca);
    ent[6] = sat32(-sa);         ent[7] = sat32(-scale_q16(d, sa));
    ent[8] = scale_q16(sp, sa);  ent[9] = scale_q16(cp, sa);
    ent[10] = ca;                ent[11] = scale_q16(d, ca);
    if (lc.pinned) begin
      ent[3] = longint'($signed(lc.span_x));
      ent[7] = longint'($signed(lc.span_y));
      ent[11] = longint'($signed(lc.span_z));
    end
    for (int r = 0; r < 3; r++) begin
      row.index = (r == 0) ? ROW_FIRST : ((r == 1) ? ROW_ONE : ROW_TWO);
      for (int c = 0; c < 4; c++) row.col[c] = ent[r * 4 + c][31:0];
      row.last = 1'b0;
      rows_due.push_back(row);
    end
    // bottom row is fixed
    row.index = ROW_LAST;
    row.col[0] = '0;
    row.col[1] = '0;
    row.col[2] = '0;
    row.col[3] = VAL_ONE;
    row.last = 1'b1;
    rows_due.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
  endtask

  function automatic logic [31:0] pick_length();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3: begin
        case ($urandom_range(0, 4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return 32'h0;
          3: return VAL_ONE;
          default: return VAL_NEG_ONE;
        endcase
      end
      default: return r;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 3) != 0) return r[15:0];
    case ($urandom_range(0, 8))
      0: return ANG_ZERO;
      1: return ANG_QUARTER;
      2: return ANG_HALF;
      3: return ANG_MQUART;
      4: return 16'h7FFF;
      5: return 16'h8001;
      6: return 16'h2000;
      7: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // offer one link beat, with an occasional gap in front of it
  task automatic send_link(input link_case_t lc);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {lc.joint, lc.distance, lc.twist, lc.offset};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    build_link_transform(lc);
    @(negedge clk);
  endtask

  // stimulus
  initial begin : link_source
    link_case_t plan [PLAN_LINKS];
    link_case_t lc;
    plan = '{
      '{32'h0, ANG_ZERO, 32'h0, ANG_ZERO, 1'b1, 32'h0, 32'h0, 32'h0},
      '{VAL_MAX, ANG_ZERO, VAL_MAX, ANG_ZERO, 1'b1, VAL_MAX, 32'h0, VAL_MAX},
      '{VAL_MIN, ANG_HALF, VAL_MIN, ANG_HALF, 1'b1, VAL_MIN, 32'h0, VAL_MAX},
      '{VAL_ONE, ANG_QUARTER, VAL_MIN, ANG_QUARTER, 1'b1, VAL_ONE, VAL_MAX, 32'h0},
      '{VAL_NEG_ONE, ANG_MQUART, VAL_MAX, ANG_MQUART, 1'b1, VAL_NEG_ONE, VAL_MAX, 32'h0},
      '{32'h0, ANG_MQUART, VAL_MIN, ANG_ZERO, 1'b1, 32'h0, VAL_NEG_MAX, 32'h0},
      '{32'h0, ANG_QUARTER, VAL_MAX, ANG_HALF, 1'b1, 32'h0, VAL_NEG_MAX, 32'h0},
      '{32'h0, ANG_ZERO, VAL_MIN, ANG_QUARTER, 1'b1, 32'h0, 32'h0, VAL_MIN},
      '{VAL_ONE, ANG_HALF, VAL_ONE, ANG_ZERO, 1'b1, VAL_ONE, 32'h0, VAL_NEG_ONE},
      '{32'h1, 16'h7FFF, 32'h1, 16'h7FFF, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'hFFFF_FFFF, 16'h8001, 32'hFFFF_FFFF, 16'h8001, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'h0, 16'h2000, 32'h0003_0000, 16'h2000, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'h1234_5678, 16'h6000, 32'h8765_4321, 16'hA000, 1'b0, 32'h0, 32'h0, 32'h0},
      '{VAL_MAX, 16'h2000, VAL_MAX, 16'hE000, 1'b0, 32'h0, 32'h0, 32'h0},
      '{VAL_MIN, 16'hE000, VAL_MIN, 16'h6000, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'h5555_5555, 16'h5555, 32'hAAAA_AAAA, 16'hAAAA, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'hAAAA_AAAA, 16'hAAAA, 32'h5555_5555, 16'h5555, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'h0, 16'h0001, 32'h7FFF_0000, 16'hFFFF, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'h0000_8000, 16'h3FFF, 32'h0000_7FFF, 16'h4001, 1'b0, 32'h0, 32'h0, 32'h0},
      '{32'hDEAD_BEEF, 16'hC001, 32'h1357_9BDF, 16'hBFFF, 1'b0, 32'h0, 32'h0, 32'h0}
    };
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int n = 0; n < TOTAL_LINKS; n++) begin
      // quiet stretch in the middle, none at all near the end
      calm = (n >= 100 && n < 140) || (n >= TOTAL_LINKS - 40);
      if (n < PLAN_LINKS) begin
        lc = plan[n];
      end else begin
        lc.offset = pick_length();
        lc.twist = pick_angle();
        lc.distance = pick_length();
        lc.joint = pick_angle();
        lc.pinned = 1'b0;
        lc.span_x = '0;
        lc.span_y = '0;
        lc.span_z = '0;
      end
      send_link(lc);
    end
    s_tvalid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && rows_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // output backpressure in random bursts
  initial begin : sink_stall
    int stall_left;
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  // compare each row beat with the oldest pending row
  always @(posedge clk) begin : row_check
    transform_row_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (rows_due.size() == 0) begin
        report_mismatch("row with none pending", 32'h0, {30'h0, m_tuser});
      end else begin
        want = rows_due.pop_front();
        if (m_tuser !== want.index)
          report_mismatch("row index", {30'h0, want.index}, {30'h0, m_tuser});
        if (m_tdata[31:0] !== want.col[0])
          report_mismatch("col_zero", want.col[0], m_tdata[31:0]);
        if (m_tdata[63:32] !== want.col[1])
          report_mismatch("col_one", want.col[1], m_tdata[63:32]);
        if (m_tdata[95:64] !== want.col[2])
          report_mismatch("col_two", want.col[2], m_tdata[95:64]);
        if (m_tdata[127:96] !== want.col[3])
          report_mismatch("col_three", want.col[3], m_tdata[127:96]);
        if (m_tlast !== want.last)
          report_mismatch("last_row", {31'h0, want.last}, {31'h0, m_tlast});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
